### rtl/esa_pkg.sv
package esa_pkg;

    // event kinds on s_tuser
    localparam logic [2:0] KIND_READ     = 3'd0;
    localparam logic [2:0] KIND_WRITE    = 3'd1;
    localparam logic [2:0] KIND_RX       = 3'd2;
    localparam logic [2:0] KIND_TX       = 3'd3;
    localparam logic [2:0] KIND_START    = 3'd4;
    localparam logic [2:0] KIND_COMMIT   = 3'd5;
    localparam logic [2:0] KIND_ROLLBACK = 3'd6;
    localparam logic [2:0] KIND_BAD      = 3'd7;

    localparam int FUNC_W    = 3;
    localparam int AMOUNT_W  = 40;
    localparam int SUM_W     = 48;
    localparam int MS_W      = 31;
    localparam int OUT_CNT_W = 32;

    // microseconds per millisecond; remainder of the serial divide stays below it
    localparam int US_PER_MS = 1000;
    localparam int REM_W     = 10;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_FIELD_W = 2 * SUM_W + 5 * OUT_CNT_W + 3 * MS_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;
    localparam int M_TUSER_W = 1;

    typedef logic [MS_W-1:0] ms_t;

endpackage

### rtl/esa_mean_unit.sv
module esa_mean_unit #(
    parameter int CNT_W = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  esa_pkg::ms_t        d,
    input  esa_pkg::ms_t        avg,
    input  logic [CNT_W-1:0]    n,
    output logic                done,
    output esa_pkg::ms_t        mean
);
    import esa_pkg::*;

    localparam int STEP_W = $clog2(MS_W);

    logic              busy_reg;
    logic              done_reg;
    logic              up_reg;
    ms_t               avg_reg;
    ms_t               quo_reg;   // dividend bits out at top, quotient bits in at bottom
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [STEP_W-1:0] step_reg;

    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    trial;
    logic              ge;

    assign shifted = {rem_reg, quo_reg[MS_W-1]};
    assign trial   = shifted - {1'b0, n_reg};
    assign ge      = (shifted >= {1'b0, n_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                up_reg   <= (d >= avg);
                quo_reg  <= (d >= avg) ? (d - avg) : (avg - d);
                rem_reg  <= '0;
                n_reg    <= n;
                avg_reg  <= avg;
                step_reg <= STEP_W'(MS_W - 1);
            end else if (busy_reg) begin
                rem_reg <= ge ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
                quo_reg <= {quo_reg[MS_W-2:0], ge};
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    // moving down rounds the step up, so the mean stays truncated
    assign done = done_reg;
    assign mean = up_reg ? (avg_reg + quo_reg)
                         : (avg_reg - quo_reg - MS_W'(rem_reg != '0));

endmodule

### rtl/event_statistics_accumulator_top.sv
// Event statistics accumulator. Each input transfer carries one event: the
// kind on s_tuser and a 40-bit amount on s_tdata. Reads and writes add their
// byte count to 48-bit totals; message, start, commit and rollback events
// bump COUNTER_BITS-wide wrapping counters, reported in their low 32 bits.
// A commit turns its microsecond duration into milliseconds (truncated) and
// updates the minimum, maximum and truncated running mean; the commit that
// brings the count to one seeds all three, and when the count wraps to zero
// the mean is held. Kind 7 changes nothing and sets m_tuser. Every event
// yields exactly one result transfer with a snapshot of all statistics.
// Sums and counter increments are bit serial over one shared full adder,
// and the divides are bit serial too: a read or write adds all 48 bits, the
// four plain counters all COUNTER_BITS bits, and a commit runs a 40-bit
// divide by 1000, the count increment, then waits on the 31-step mean divider
// when the count is two or more, with one state each to accept, update and load.
// One event is in work at a time; the output register lets
// the next event enter while the previous result waits for m_tready.
module event_statistics_accumulator_top #(
    parameter int COUNTER_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input events
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [esa_pkg::S_TDATA_W-1:0]  s_tdata,  // amount
    input  logic [esa_pkg::S_TUSER_W-1:0]  s_tuser,  // func
    // statistics results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_bytes_total, written_bytes_total, messages_in, messages_out,
    // started_count, committed_count, rolled_back_count, longest_ms,
    // shortest_ms, mean_ms, zero pad
    output logic [esa_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [esa_pkg::M_TUSER_W-1:0]  m_tuser   // bad_kind
);
    import esa_pkg::*;

    localparam int LEN_MAX = (SUM_W > COUNTER_BITS) ? SUM_W : COUNTER_BITS;
    localparam int BIT_W   = $clog2(LEN_MAX);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADD  = 3'd1;   // serial add / increment
    localparam logic [2:0] ST_DIV  = 3'd2;   // serial divide by 1000
    localparam logic [2:0] ST_UPD  = 3'd3;   // min / max / seed
    localparam logic [2:0] ST_MEAN = 3'd4;   // wait on the mean divider
    localparam logic [2:0] ST_OUT  = 3'd5;   // load the output register

    logic [2:0]              state_reg;
    logic [2:0]              tgt_reg;
    logic [AMOUNT_W-1:0]     amt_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [BIT_W-1:0]        bit_reg;
    logic                    carry_reg;
    logic                    bad_reg;

    logic [SUM_W-1:0]        read_sum_reg;
    logic [SUM_W-1:0]        write_sum_reg;
    logic [COUNTER_BITS-1:0] rx_cnt_reg;
    logic [COUNTER_BITS-1:0] tx_cnt_reg;
    logic [COUNTER_BITS-1:0] start_cnt_reg;
    logic [COUNTER_BITS-1:0] commit_cnt_reg;
    logic [COUNTER_BITS-1:0] rollback_cnt_reg;
    ms_t                     max_reg;
    ms_t                     min_reg;
    ms_t                     avg_reg;

    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;
    logic                    m_tuser_reg;

    logic                    a_bit;
    logic                    b_bit;
    logic                    s_bit;
    logic                    c_next;
    logic [REM_W:0]          div_shift;
    logic                    div_ge;
    logic [REM_W:0]          div_trial;
    ms_t                     dur_ms;
    logic                    mean_start;
    logic                    mean_done;
    ms_t                     mean_ms;
    logic                    out_load;

    // shared full adder: low bit of the selected register plus amount bit
    always_comb begin
        unique case (tgt_reg)
            KIND_READ:     a_bit = read_sum_reg[0];
            KIND_WRITE:    a_bit = write_sum_reg[0];
            KIND_RX:       a_bit = rx_cnt_reg[0];
            KIND_TX:       a_bit = tx_cnt_reg[0];
            KIND_START:    a_bit = start_cnt_reg[0];
            KIND_COMMIT:   a_bit = commit_cnt_reg[0];
            KIND_ROLLBACK: a_bit = rollback_cnt_reg[0];
            default:       a_bit = 1'b0;
        endcase
    end

    assign b_bit  = (tgt_reg == KIND_READ || tgt_reg == KIND_WRITE) ? amt_reg[0] : 1'b0;
    assign s_bit  = a_bit ^ b_bit ^ carry_reg;
    assign c_next = (a_bit & b_bit) | (a_bit & carry_reg) | (b_bit & carry_reg);

    // restoring divide by 1000, one quotient bit per cycle into amt_reg
    assign div_shift = {rem_reg, amt_reg[AMOUNT_W-1]};
    assign div_ge    = (div_shift >= (REM_W + 1)'(US_PER_MS));
    assign div_trial = div_shift - (REM_W + 1)'(US_PER_MS);

    assign dur_ms     = amt_reg[MS_W-1:0];
    assign mean_start = (state_reg == ST_UPD) &&
                        (commit_cnt_reg != COUNTER_BITS'(1)) &&
                        (commit_cnt_reg != '0);
    assign out_load   = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    esa_mean_unit #(
        .CNT_W (COUNTER_BITS)
    ) u_mean (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mean_start),
        .d       (dur_ms),
        .avg     (avg_reg),
        .n       (commit_cnt_reg),
        .done    (mean_done),
        .mean    (mean_ms)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            read_sum_reg     <= '0;
            write_sum_reg    <= '0;
            rx_cnt_reg       <= '0;
            tx_cnt_reg       <= '0;
            start_cnt_reg    <= '0;
            commit_cnt_reg   <= '0;
            rollback_cnt_reg <= '0;
            max_reg          <= '0;
            min_reg          <= '0;
            avg_reg          <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        tgt_reg <= s_tuser;
                        amt_reg <= s_tdata;
                        rem_reg <= '0;
                        bad_reg <= (s_tuser == KIND_BAD);
                        if (s_tuser == KIND_BAD) begin
                            state_reg <= ST_OUT;
                        end else if (s_tuser == KIND_COMMIT) begin
                            bit_reg   <= BIT_W'(AMOUNT_W - 1);
                            state_reg <= ST_DIV;
                        end else if (s_tuser == KIND_READ || s_tuser == KIND_WRITE) begin
                            bit_reg   <= BIT_W'(SUM_W - 1);
                            carry_reg <= 1'b0;
                            state_reg <= ST_ADD;
                        end else begin
                            bit_reg   <= BIT_W'(COUNTER_BITS - 1);
                            carry_reg <= 1'b1;
                            state_reg <= ST_ADD;
                        end
                    end
                end
                ST_DIV: begin
                    rem_reg <= div_ge ? div_trial[REM_W-1:0] : div_shift[REM_W-1:0];
                    amt_reg <= {amt_reg[AMOUNT_W-2:0], div_ge};
                    if (bit_reg == '0) begin
                        bit_reg   <= BIT_W'(COUNTER_BITS - 1);
                        carry_reg <= 1'b1;
                        state_reg <= ST_ADD;
                    end else begin
                        bit_reg <= bit_reg - 1'b1;
                    end
                end
                ST_ADD: begin
                    carry_reg <= c_next;
                    if (tgt_reg == KIND_READ || tgt_reg == KIND_WRITE) begin
                        amt_reg <= {1'b0, amt_reg[AMOUNT_W-1:1]};
                    end
                    if (tgt_reg == KIND_READ)
                        read_sum_reg <= {s_bit, read_sum_reg[SUM_W-1:1]};
                    if (tgt_reg == KIND_WRITE)
                        write_sum_reg <= {s_bit, write_sum_reg[SUM_W-1:1]};
                    if (tgt_reg == KIND_RX)
                        rx_cnt_reg <= {s_bit, rx_cnt_reg[COUNTER_BITS-1:1]};
                    if (tgt_reg == KIND_TX)
                        tx_cnt_reg <= {s_bit, tx_cnt_reg[COUNTER_BITS-1:1]};
                    if (tgt_reg == KIND_START)
                        start_cnt_reg <= {s_bit, start_cnt_reg[COUNTER_BITS-1:1]};
                    if (tgt_reg == KIND_COMMIT)
                        commit_cnt_reg <= {s_bit, commit_cnt_reg[COUNTER_BITS-1:1]};
                    if (tgt_reg == KIND_ROLLBACK)
                        rollback_cnt_reg <= {s_bit, rollback_cnt_reg[COUNTER_BITS-1:1]};
                    if (bit_reg == '0) begin
                        state_reg <= (tgt_reg == KIND_COMMIT) ? ST_UPD : ST_OUT;
                    end else begin
                        bit_reg <= bit_reg - 1'b1;
                    end
                end
                ST_UPD: begin
                    if (commit_cnt_reg == COUNTER_BITS'(1)) begin
                        // first commit after reset or wrap seeds everything
                        max_reg   <= dur_ms;
                        min_reg   <= dur_ms;
                        avg_reg   <= dur_ms;
                        state_reg <= ST_OUT;
                    end else begin
                        if (dur_ms > max_reg) max_reg <= dur_ms;
                        if (dur_ms < min_reg) min_reg <= dur_ms;
                        // count wrapped to zero: mean held
                        state_reg <= mean_start ? ST_MEAN : ST_OUT;
                    end
                end
                ST_MEAN: begin
                    if (mean_done) begin
                        avg_reg   <= mean_ms;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // output register: snapshot of all statistics
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, avg_reg, min_reg, max_reg,
                            OUT_CNT_W'(rollback_cnt_reg), OUT_CNT_W'(commit_cnt_reg),
                            OUT_CNT_W'(start_cnt_reg), OUT_CNT_W'(tx_cnt_reg),
                            OUT_CNT_W'(rx_cnt_reg), write_sum_reg, read_sum_reg};
            m_tuser_reg <= bad_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // mean divider never sees a zero or unit count
    a_mean_n: assert property (@(posedge aclk) disable iff (!aresetn)
        mean_start |-> (commit_cnt_reg != '0 && commit_cnt_reg != COUNTER_BITS'(1)))
        else $error("mean divider started with count below two");

    // divider finishes only while the sequencer waits for it
    a_mean_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mean_done |-> (state_reg == ST_MEAN))
        else $error("mean result outside wait state");

    // seeding makes all three duration statistics equal
    a_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD && commit_cnt_reg == COUNTER_BITS'(1))
        |=> (min_reg == max_reg && max_reg == avg_reg))
        else $error("seed commit left min, max, mean unequal");

    // the running mean stays between minimum and maximum
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && commit_cnt_reg != '0)
        |-> (min_reg <= avg_reg && avg_reg <= max_reg))
        else $error("mean outside min/max range");

    // a result is loaded only after the statistics are settled
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result loaded outside output state");

endmodule
